### rtl/core/gsms_pkg.sv
// ----------------------------------------------------------------------------
// Median filter package
// Shared types and constants of the gated sliding median filter.
// ----------------------------------------------------------------------------
package gsms_pkg;

  localparam int unsigned Window = 10;
  localparam int unsigned IdxW = $clog2(Window);
  localparam int unsigned CntW = 4;
  localparam logic [15:0] AmpCeil = 16'd30000;
  localparam logic [15:0] LowerReset = 16'd320;
  localparam logic [15:0] UpperReset = 16'd10240;

  localparam logic CfgLower = 1'b0;
  localparam logic CfgUpper = 1'b1;

  localparam logic [2:0] StTooFar = 3'd0;
  localparam logic [2:0] StTooNear = 3'd1;
  localparam logic [2:0] StFilling = 3'd2;
  localparam logic [2:0] StMedian = 3'd3;
  localparam logic [2:0] StCleared = 3'd4;

  typedef struct packed {
    logic [15:0] range;
    logic [14:0] amp;
  } entry_t;

  typedef struct packed {
    logic load;      // copy window into sort array, reset indices to first pair
    logic step;      // one compare and swap, advance i and j
    logic finish;    // compute median and latch result
  } cmd_t;

  typedef struct packed {
    logic sort_done;
  } stat_t;

endpackage

### rtl/core/gsms_datapath.sv
// ----------------------------------------------------------------------------
// Median filter datapath
// Window store, sort array with one compare-and-swap unit, median math.
// ----------------------------------------------------------------------------
module gsms_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic                        clr_i,
  input  logic [15:0]                 range_i,
  input  logic [14:0]                 amp_i,
  input  gsms_pkg::cmd_t              cmd_i,
  output gsms_pkg::stat_t             stat_o,
  output logic [gsms_pkg::CntW-1:0]   count_o,
  output logic [16:0]                 med_range_o,
  output logic [14:0]                 med_amp_o,
  output logic [14:0]                 soft_o
);

  localparam int unsigned W = gsms_pkg::Window;
  localparam int unsigned IW = gsms_pkg::IdxW;
  // Softness is diff * 256 / 300, taken as diff * ceil(2^30 / 300) >> 22.
  localparam logic [21:0] SoftRecip = 22'd3579140;

  gsms_pkg::entry_t store_q [W];
  gsms_pkg::entry_t sort_q [W];
  logic [IW-1:0] slot_q, slot_d;
  logic [gsms_pkg::CntW-1:0] count_q, count_d;
  logic [IW-1:0] i_q, j_q;
  logic [16:0] mr_q;
  logic [14:0] ma_q;
  logic [14:0] soft_q;
  logic        sq_q;

  gsms_pkg::entry_t ei, ej;
  logic swap;
  logic [15:0] amp_sum;
  logic [14:0] ma_c;
  logic [14:0] diff;
  logic [36:0] prod;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      store_q[slot_q] <= '{range: range_i, amp: amp_i};
    end
  end

  always_comb begin
    slot_d = slot_q;
    count_d = count_q;
    if (clr_i) begin
      slot_d = '0;
      count_d = '0;
    end else if (wr_en_i) begin
      slot_d = (slot_q == IW'(W - 1)) ? '0 : slot_q + 1'b1;
      if (count_q != gsms_pkg::CntW'(W)) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      count_q <= '0;
      i_q <= '0;
      j_q <= '0;
      sq_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
      count_q <= count_d;
      sq_q <= 1'b0;
      if (cmd_i.load) begin
        i_q <= '0;
        j_q <= IW'(1);
      end else if (cmd_i.step) begin
        if (j_q == IW'(W - 1)) begin
          if (i_q == IW'(W - 2)) begin
            sq_q <= 1'b1;
          end else begin
            i_q <= i_q + 1'b1;
            j_q <= i_q + IW'(2);
          end
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
    end
  end

  assign ei = sort_q[i_q];
  assign ej = sort_q[j_q];
  assign swap = ei.amp > ej.amp;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sort_q <= store_q;
    end else if (cmd_i.step && swap) begin
      sort_q[i_q] <= ej;
      sort_q[j_q] <= ei;
    end
  end

  always_comb begin
    if ((W % 2) == 0) begin
      amp_sum = {1'b0, sort_q[W/2].amp} + {1'b0, sort_q[W/2-1].amp};
      ma_c = amp_sum[15:1];
    end else begin
      amp_sum = '0;
      ma_c = sort_q[W/2].amp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if ((W % 2) == 0) begin
        mr_q <= {1'b0, sort_q[W/2].range} + {1'b0, sort_q[W/2-1].range};
      end else begin
        mr_q <= {sort_q[W/2].range, 1'b0};
      end
      ma_q <= ma_c;
    end
  end

  assign diff = gsms_pkg::AmpCeil[14:0] - ma_q;
  assign prod = 37'(diff) * 37'(SoftRecip);

  always_ff @(posedge clk_i) begin
    soft_q <= prod[36:22];
  end

  assign stat_o.sort_done = sq_q;
  assign count_o = count_q;
  assign med_range_o = mr_q;
  assign med_amp_o = ma_q;
  assign soft_o = soft_q;

endmodule

### rtl/core/gsms_ctrl.sv
// ----------------------------------------------------------------------------
// Median filter controller
// Gates readings, sequences the sort and drives the result register.
// ----------------------------------------------------------------------------
module gsms_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      command_i,
  input  logic [15:0]               raw_i,
  input  logic [15:0]               lower_i,
  input  logic [15:0]               upper_i,
  input  logic [gsms_pkg::CntW-1:0] count_i,
  input  gsms_pkg::stat_t           stat_i,
  output gsms_pkg::cmd_t            cmd_o,
  output logic                      wr_en_o,
  output logic                      clr_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                status_o,
  output logic                      use_med_o
);

  typedef enum logic [2:0] {Idle, Load, Sort, Finish, Emit} state_e;

  state_e state_q;
  logic [2:0] status_q;
  logic       valid_q;
  logic       full;
  logic       take;

  assign full = count_i == gsms_pkg::CntW'(gsms_pkg::Window);
  assign in_ready_o = (state_q == Idle) && !valid_q;
  assign take = in_valid_i && in_ready_o;
  assign clr_o = take && command_i;
  assign wr_en_o = take && !command_i && (raw_i < upper_i) && (raw_i >= lower_i);
  assign cmd_o.load = state_q == Load;
  assign cmd_o.step = (state_q == Sort) && !stat_i.sort_done;
  assign cmd_o.finish = state_q == Finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      status_q <= gsms_pkg::StTooFar;
      valid_q <= 1'b0;
    end else begin
      if (valid_q && out_ready_i) begin
        valid_q <= 1'b0;
      end
      unique case (state_q)
        Idle: begin
          if (take) begin
            if (command_i) begin
              status_q <= gsms_pkg::StCleared;
              valid_q <= 1'b1;
            end else if (raw_i >= upper_i) begin
              status_q <= gsms_pkg::StTooFar;
              valid_q <= 1'b1;
            end else if (raw_i < lower_i) begin
              status_q <= gsms_pkg::StTooNear;
              valid_q <= 1'b1;
            end else if (full) begin
              status_q <= gsms_pkg::StMedian;
              state_q <= Load;
            end else begin
              status_q <= gsms_pkg::StFilling;
              valid_q <= 1'b1;
            end
          end
        end
        Load: begin
          state_q <= Sort;
        end
        Sort: begin
          if (stat_i.sort_done) begin
            state_q <= Finish;
          end
        end
        Finish: begin
          state_q <= Emit;
        end
        Emit: begin
          valid_q <= 1'b1;
          state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assign out_valid_o = valid_q;
  assign status_o = status_q;
  assign use_med_o = status_q == gsms_pkg::StMedian;

endmodule

### rtl/core/gated_sliding_median_softness.sv
// ----------------------------------------------------------------------------
// Gated sliding median with softness
// Range gate, ten-entry ring window, sorted median and softness estimate.
// ----------------------------------------------------------------------------
// Each input item is a clear command or a range/amplitude reading; each
// yields exactly one result item on the master stream.
// A clear, a rejected reading or a reading while the window fills gives its
// result in the cycle after acceptance, and the next item is taken once
// that result has been taken. Once the window is full, a reading is written,
// the window is copied into the sort array, and an exchange sort runs
// through one compare-and-swap unit, one pair per cycle; the median is
// then latched in the Finish state and the result is raised in Emit.
// One item is in work at a time: s_axis_tready is low from acceptance until
// the result has been taken, so a stalled receiver holds the result and the
// input stalls with it.
// Reset clears the window count, write slot and control; limits return to
// 320 and 10240. The user must write limits on the cfg channel (index 0
// lower, 1 upper) only while the block is idle; the block has no check for it.
// ----------------------------------------------------------------------------
module gated_sliding_median_softness (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // raw_range[15:0], amplitude[31:16]
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // status, fill_count, mid_range,
                                     // median_amplitude, softness
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] lower_q, upper_q;
  logic [15:0] amp_raw;
  logic [14:0] amp_cl;
  gsms_pkg::cmd_t cmd;
  gsms_pkg::stat_t stat;
  logic wr_en, clr, use_med;
  logic [2:0] status;
  logic [gsms_pkg::CntW-1:0] count;
  logic [16:0] mr;
  logic [14:0] ma, soft_pct;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= gsms_pkg::LowerReset;
      upper_q <= gsms_pkg::UpperReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gsms_pkg::CfgLower: lower_q <= cfg_data_i;
        gsms_pkg::CfgUpper: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign amp_raw = s_axis_tdata[31:16];
  assign amp_cl = (amp_raw > gsms_pkg::AmpCeil) ? gsms_pkg::AmpCeil[14:0] : amp_raw[14:0];

  gsms_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .command_i (s_axis_tuser), .raw_i (s_axis_tdata[15:0]),
    .lower_i (lower_q), .upper_i (upper_q),
    .count_i (count), .stat_i (stat), .cmd_o (cmd),
    .wr_en_o (wr_en), .clr_o (clr),
    .out_valid_o (m_axis_tvalid), .out_ready_i (m_axis_tready),
    .status_o (status), .use_med_o (use_med)
  );

  gsms_datapath u_dp (
    .clk_i, .rst_ni,
    .wr_en_i (wr_en), .clr_i (clr),
    .range_i (s_axis_tdata[15:0]), .amp_i (amp_cl),
    .cmd_i (cmd), .stat_o (stat), .count_o (count),
    .med_range_o (mr), .med_amp_o (ma), .soft_o (soft_pct)
  );

  assign m_axis_tdata = {2'b00, (use_med ? soft_pct : 15'd0), (use_med ? ma : 15'd0),
                         (use_med ? mr : 17'd0), count, status};

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Median filter testbench
// Drives readings and clear commands into the gated sliding median block,
// writes the range limits between phases, and checks every result item
// field by field against a behavioral median predictor or directed results.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [14:0] soft_pct;
    logic [14:0] mamp;
    logic [16:0] mrange;
    logic [3:0]  fill;
    logic [2:0]  status;
  } result_t;

  typedef struct {
    logic        clr;
    logic [15:0] raw;
    logic [15:0] amp;
    logic        known;
    result_t     res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = gsms_pkg::CfgLower;
  logic [15:0] cfg_data_i = '0;

  gated_sliding_median_softness u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gsms_pkg::entry_t win_q [gsms_pkg::Window];
  int unsigned slot_q, count_q;
  logic [15:0] lower_q, upper_q;
  result_t expected_q [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit calm = 1'b0;
  bit hold_rx = 1'b0;

  function automatic result_t predict_median(logic clr, logic [15:0] raw, logic [15:0] amp);
    result_t r;
    gsms_pkg::entry_t s [gsms_pkg::Window];
    gsms_pkg::entry_t t;
    logic [15:0] a;
    int unsigned ma;
    r = '0;
    if (clr) begin
      slot_q = 0;
      count_q = 0;
      r.status = gsms_pkg::StCleared;
      return r;
    end
    r.fill = count_q[3:0];
    if (raw >= upper_q) begin
      r.status = gsms_pkg::StTooFar;
      return r;
    end
    if (raw < lower_q) begin
      r.status = gsms_pkg::StTooNear;
      return r;
    end
    a = (amp > gsms_pkg::AmpCeil) ? gsms_pkg::AmpCeil : amp;
    win_q[slot_q] = '{range: raw, amp: a[14:0]};
    slot_q = (slot_q + 1) % gsms_pkg::Window;
    if (count_q < gsms_pkg::Window) begin
      count_q++;
      r.status = gsms_pkg::StFilling;
      r.fill = count_q[3:0];
      return r;
    end
    s = win_q;
    for (int i = 0; i < gsms_pkg::Window; i++)
      for (int j = i + 1; j < gsms_pkg::Window; j++)
        if (s[i].amp > s[j].amp) begin
          t = s[i];
          s[i] = s[j];
          s[j] = t;
        end
    r.status = gsms_pkg::StMedian;
    r.mrange = 17'(s[gsms_pkg::Window/2].range) + 17'(s[gsms_pkg::Window/2-1].range);
    ma = (int'(s[gsms_pkg::Window/2].amp) + int'(s[gsms_pkg::Window/2-1].amp)) / 2;
    r.mamp = ma[14:0];
    r.soft_pct = 15'(((30000 - ma) * 256) / 300);
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= !hold_rx && (calm || $urandom_range(99) >= 11);
  end

  always @(posedge clk_i) begin
    result_t got, exp;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(result_t)-1:0];
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        exp = expected_q.pop_front();
        if (got.status !== exp.status) begin
          $error("status exp %0d got %0d", exp.status, got.status); errors++;
        end
        if (got.fill !== exp.fill) begin
          $error("fill_count exp %0d got %0d", exp.fill, got.fill); errors++;
        end
        if (got.mrange !== exp.mrange) begin
          $error("mid_range exp %0d got %0d", exp.mrange, got.mrange); errors++;
        end
        if (got.mamp !== exp.mamp) begin
          $error("median_amplitude exp %0d got %0d", exp.mamp, got.mamp); errors++;
        end
        if (got.soft_pct !== exp.soft_pct) begin
          $error("softness exp %0d got %0d", exp.soft_pct, got.soft_pct); errors++;
        end
      end
    end
  end

  task automatic send_item(logic clr, logic [15:0] raw, logic [15:0] amp);
    logic rdy;
    while (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= clr;
    s_axis_tdata <= {amp, raw};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    expected_q.push_back(predict_median(clr, raw, amp));
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_limit(logic idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == gsms_pkg::CfgLower) lower_q = val; else upper_q = val;
  endtask

  task automatic random_reading();
    int unsigned k;
    logic [15:0] raw, amp;
    k = $urandom_range(99);
    if (k < 3) begin
      send_item(1'b1, 16'($urandom), 16'($urandom));
      return;
    end
    if (k < 85 && upper_q > lower_q) raw = 16'($urandom_range(upper_q - 1, lower_q));
    else raw = 16'($urandom);
    amp = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(30000));
    send_item(1'b0, raw, amp);
  endtask

  row_t rows [] = '{
    '{1'b0, 16'd10240, 16'd5, 1'b1, '{0, 0, 0, 0, gsms_pkg::StTooFar}},
    '{1'b0, 16'hFFFF, 16'hFFFF, 1'b1, '{0, 0, 0, 0, gsms_pkg::StTooFar}},
    '{1'b0, 16'd319, 16'd5, 1'b1, '{0, 0, 0, 0, gsms_pkg::StTooNear}},
    '{1'b0, 16'd0, 16'd0, 1'b1, '{0, 0, 0, 0, gsms_pkg::StTooNear}},
    '{1'b0, 16'd320, 16'hFFFF, 1'b1, '{0, 0, 0, 1, gsms_pkg::StFilling}},
    '{1'b0, 16'd10239, 16'd0, 1'b0, '0},
    '{1'b0, 16'd5000, 16'd30000, 1'b0, '0},
    '{1'b0, 16'd5000, 16'd30001, 1'b0, '0},
    '{1'b0, 16'd700, 16'd100, 1'b0, '0},
    '{1'b0, 16'd800, 16'd100, 1'b0, '0},
    '{1'b0, 16'd900, 16'd100, 1'b0, '0},
    '{1'b0, 16'd1000, 16'd20000, 1'b0, '0},
    '{1'b0, 16'd1100, 16'd15000, 1'b0, '0},
    '{1'b0, 16'd1200, 16'd15000, 1'b0, '0},
    '{1'b0, 16'd1300, 16'd15001, 1'b0, '0},
    '{1'b0, 16'd1400, 16'd0, 1'b0, '0},
    '{1'b0, 16'd9000, 16'd40000, 1'b0, '0},
    '{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, '{0, 0, 0, 0, gsms_pkg::StCleared}},
    '{1'b0, 16'd300, 16'd5, 1'b1, '{0, 0, 0, 0, gsms_pkg::StTooNear}},
    '{1'b0, 16'd2000, 16'd7, 1'b1, '{0, 0, 0, 1, gsms_pkg::StFilling}}
  };

  initial begin
    slot_q = 0;
    count_q = 0;
    lower_q = gsms_pkg::LowerReset;
    upper_q = gsms_pkg::UpperReset;
    foreach (win_q[i]) win_q[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_item(rows[i].clr, rows[i].raw, rows[i].amp);
      if (rows[i].known) expected_q[$] = rows[i].res;
    end
    s_axis_tvalid <= 1'b0;
    drain_results();

    // Receiver holds off while the sender keeps offering.
    fork
      begin
        hold_rx = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      begin
        repeat (30) random_reading();
        s_axis_tvalid <= 1'b0;
      end
    join
    drain_results();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_limit(gsms_pkg::CfgLower, 16'd0);
          write_limit(gsms_pkg::CfgUpper, 16'hFFFF);
        end
        1: begin
          write_limit(gsms_pkg::CfgLower, 16'hFFFF);
          write_limit(gsms_pkg::CfgUpper, 16'd0);
        end
        2: begin
          write_limit(gsms_pkg::CfgLower, 16'd1000);
          write_limit(gsms_pkg::CfgUpper, 16'd1000);
        end
        3: begin
          write_limit(gsms_pkg::CfgLower, 16'd100);
          write_limit(gsms_pkg::CfgUpper, 16'd2000);
        end
        4: begin
          write_limit(gsms_pkg::CfgLower, 16'd5000);
          write_limit(gsms_pkg::CfgUpper, 16'd3000);
        end
        default: begin
          write_limit(gsms_pkg::CfgLower, gsms_pkg::LowerReset);
          write_limit(gsms_pkg::CfgUpper, gsms_pkg::UpperReset);
        end
      endcase
      cfg_valid_i <= 1'b0;
      calm = (phase == 3);
      repeat (phase == 1 || phase == 2 || phase == 4 ? 60 : 520) random_reading();
      s_axis_tvalid <= 1'b0;
      calm = 1'b0;
      drain_results();
    end

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

### files.f
rtl/core/gsms_pkg.sv
rtl/core/gsms_datapath.sv
rtl/core/gsms_ctrl.sv
rtl/core/gated_sliding_median_softness.sv
verif/testbench.sv
